[hdl/sha1_stream_hasher_top_macros.svh]
// ----------------------------------------------------------------------------
// SHA-1 stream hasher assertion macros
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SHA1_STREAM_HASHER_TOP_MACROS_SVH
`define SHA1_STREAM_HASHER_TOP_MACROS_SVH

// check on every edge outside reset
`define SHA1SH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every edge, reset included
`define SHA1SH_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/sha1sh_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-1 stream hasher package
// Shared constants, control structs and round functions.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

  localparam int unsigned FILL_W     = 6;
  localparam int unsigned ROUND_W    = 7;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned NUM_WORDS  = 5;
  localparam int unsigned BCOUNT_W   = 61;
  localparam int unsigned WIN_W      = 512;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [7:0]         PAD_BYTE   = 8'h80;
  localparam logic [FILL_W-1:0]  LEN_POS    = 6'd56;
  localparam logic [FILL_W-1:0]  FILL_LAST  = 6'd63;
  localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;
  localparam logic [IDX_W-1:0]   IDX_LAST   = 3'd4;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [ROUND_W-1:0] RND_20 = 7'd20;
  localparam logic [ROUND_W-1:0] RND_40 = 7'd40;
  localparam logic [ROUND_W-1:0] RND_60 = 7'd60;

  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_in;
    logic       shift_word;
  } sched_ctrl_t;

  typedef struct packed {
    logic               load;
    logic               round;
    logic               fold;
    logic               reload;
    logic [ROUND_W-1:0] rnd;
    logic [IDX_W-1:0]   idx;
  } core_ctrl_t;

  function automatic logic [31:0] sha1_k(input logic [ROUND_W-1:0] rnd);
    logic [31:0] k;
    if (rnd < RND_20) begin
      k = K0;
    end else if (rnd < RND_40) begin
      k = K1;
    end else if (rnd < RND_60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

  function automatic logic [31:0] sha1_f(input logic [ROUND_W-1:0] rnd,
                                         input logic [31:0] b,
                                         input logic [31:0] c,
                                         input logic [31:0] d);
    logic [31:0] f;
    if (rnd < RND_20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < RND_40) begin
      f = b ^ c ^ d;
    end else if (rnd < RND_60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

[hdl/sha1sh_sched.sv]
// ----------------------------------------------------------------------------
// SHA-1 stream hasher message window
// 64-byte shift line that collects the block and expands the schedule.
// ----------------------------------------------------------------------------
module sha1sh_sched (
  input  logic                  clk_i,
  input  sha1sh_pkg::sched_ctrl_t ctrl_i,
  output logic [31:0]           w_o
);

  logic [sha1sh_pkg::WIN_W-1:0] win_q, win_d;
  logic [31:0]                  mix;
  logic [31:0]                  w_new;

  assign mix   = win_q[95:64] ^ win_q[255:224] ^ win_q[447:416] ^ win_q[511:480];
  assign w_new = {mix[30:0], mix[31]};
  assign w_o   = win_q[511:480];

  always_comb begin
    win_d = win_q;
    if (ctrl_i.shift_byte) begin
      win_d = {win_q[503:0], ctrl_i.byte_in};
    end else if (ctrl_i.shift_word) begin
      win_d = {win_q[479:0], w_new};
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

[hdl/sha1sh_core.sv]
// ----------------------------------------------------------------------------
// SHA-1 stream hasher round core
// Shared round datapath, working variables and chaining words.
// ----------------------------------------------------------------------------
module sha1sh_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sha1sh_pkg::core_ctrl_t ctrl_i,
  input  logic [31:0]            w_i,
  output logic [31:0]            word_o
);

  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] h0_q, h1_q, h2_q, h3_q, h4_q;
  logic [31:0] t;

  assign t = {a_q[26:0], a_q[31:27]}
           + sha1sh_pkg::sha1_f(ctrl_i.rnd, b_q, c_q, d_q)
           + e_q + sha1sh_pkg::sha1_k(ctrl_i.rnd) + w_i;

  always_comb begin
    unique case (ctrl_i.idx)
      3'd0:    word_o = h0_q;
      3'd1:    word_o = h1_q;
      3'd2:    word_o = h2_q;
      3'd3:    word_o = h3_q;
      3'd4:    word_o = h4_q;
      default: word_o = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      a_q <= h0_q;
      b_q <= h1_q;
      c_q <= h2_q;
      d_q <= h3_q;
      e_q <= h4_q;
    end else if (ctrl_i.round) begin
      a_q <= t;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h0_q <= sha1sh_pkg::IV0;
      h1_q <= sha1sh_pkg::IV1;
      h2_q <= sha1sh_pkg::IV2;
      h3_q <= sha1sh_pkg::IV3;
      h4_q <= sha1sh_pkg::IV4;
    end else if (ctrl_i.fold) begin
      h0_q <= h0_q + a_q;
      h1_q <= h1_q + b_q;
      h2_q <= h2_q + c_q;
      h3_q <= h3_q + d_q;
      h4_q <= h4_q + e_q;
    end else if (ctrl_i.reload) begin
      h0_q <= sha1sh_pkg::IV0;
      h1_q <= sha1sh_pkg::IV1;
      h2_q <= sha1sh_pkg::IV2;
      h3_q <= sha1sh_pkg::IV3;
      h4_q <= sha1sh_pkg::IV4;
    end
  end

endmodule

[hdl/sha1_stream_hasher_top.sv]
// ----------------------------------------------------------------------------
// SHA-1 stream hasher top level
// Byte-serial SHA-1 engine: absorbs bytes, pads on finish, emits the digest.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_stall_o   | operation_i, data_byte_i
//  out     | output    | out_valid_o / out_stall_i | digest_word_o, word_index_o,
//          |           |                           | last_word_o
//
//  An absorb request shifts one byte into the window; the 64th byte of a block
//  then starts 80 rounds on the single round unit and a fold into the chain.
//  A finish request pads the block out to 64 bytes and hashes it as above, with
//  one extra padded block when the length does not fit, then hands out the digest.
//  Reset loads the initial chaining words and clears the byte and bit counts.
//  A stalled output holds its word; after the last word, the next request is taken meanwhile.
module sha1_stream_hasher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FOLD  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [sha1sh_pkg::FILL_W-1:0]   fill_q, fill_d;
  logic [sha1sh_pkg::BCOUNT_W-1:0] bcount_q, bcount_d;
  logic [sha1sh_pkg::ROUND_W-1:0]  rnd_q, rnd_d;
  logic [sha1sh_pkg::IDX_W-1:0]    emit_q, emit_d;
  logic first_q, first_d;
  logic extra_q, extra_d;
  logic final_q, final_d;
  logic finish_q, finish_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_word_q, out_word_d;
  logic [2:0]  out_idx_q, out_idx_d;
  logic        out_last_q, out_last_d;

  logic                   in_acc;
  logic                   eff_extra;
  logic [63:0]            bit_len;
  logic [7:0]             len_byte;
  logic [7:0]             pad_byte;
  logic [31:0]            w;
  logic [31:0]            chain_word;
  sha1sh_pkg::sched_ctrl_t sched_ctrl;
  sha1sh_pkg::core_ctrl_t  core_ctrl;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign bit_len    = {bcount_q, 3'b000};
  assign eff_extra  = first_q ? (fill_q >= sha1sh_pkg::LEN_POS) : extra_q;

  always_comb begin
    case (fill_q[2:0])
      3'd0:    len_byte = bit_len[63:56];
      3'd1:    len_byte = bit_len[55:48];
      3'd2:    len_byte = bit_len[47:40];
      3'd3:    len_byte = bit_len[39:32];
      3'd4:    len_byte = bit_len[31:24];
      3'd5:    len_byte = bit_len[23:16];
      3'd6:    len_byte = bit_len[15:8];
      default: len_byte = bit_len[7:0];
    endcase
  end

  always_comb begin
    if (first_q) begin
      pad_byte = sha1sh_pkg::PAD_BYTE;
    end else if ((fill_q >= sha1sh_pkg::LEN_POS) && !extra_q) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    bcount_d    = bcount_q;
    rnd_d       = rnd_q;
    emit_d      = emit_q;
    first_d     = first_q;
    extra_d     = extra_q;
    final_d     = final_q;
    finish_d    = finish_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;

    sched_ctrl         = '0;
    core_ctrl          = '0;
    core_ctrl.rnd      = rnd_q;
    core_ctrl.idx      = emit_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (operation_i == sha1sh_pkg::OP_ABSORB) begin
            sched_ctrl.shift_byte = 1'b1;
            sched_ctrl.byte_in    = data_byte_i;
            fill_d   = fill_q + 6'd1;
            bcount_d = bcount_q + 61'd1;
            finish_d = 1'b0;
            if (fill_q == sha1sh_pkg::FILL_LAST) begin
              core_ctrl.load = 1'b1;
              rnd_d   = '0;
              state_d = ST_ROUND;
            end
          end else begin
            first_d  = 1'b1;
            extra_d  = 1'b0;
            final_d  = 1'b0;
            finish_d = 1'b1;
            state_d  = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        sched_ctrl.shift_byte = 1'b1;
        sched_ctrl.byte_in    = pad_byte;
        fill_d  = fill_q + 6'd1;
        first_d = 1'b0;
        extra_d = eff_extra;
        if (fill_q == sha1sh_pkg::FILL_LAST) begin
          final_d        = !eff_extra;
          extra_d        = 1'b0;
          core_ctrl.load = 1'b1;
          rnd_d          = '0;
          state_d        = ST_ROUND;
        end
      end
      ST_ROUND: begin
        core_ctrl.round       = 1'b1;
        sched_ctrl.shift_word = 1'b1;
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == sha1sh_pkg::ROUND_LAST) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        core_ctrl.fold = 1'b1;
        if (finish_q && final_q) begin
          emit_d  = '0;
          state_d = ST_EMIT;
        end else if (finish_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_word_d  = chain_word;
          out_idx_d   = emit_q;
          out_last_d  = (emit_q == sha1sh_pkg::IDX_LAST);
          if (emit_q == sha1sh_pkg::IDX_LAST) begin
            core_ctrl.reload = 1'b1;
            bcount_d = '0;
            fill_d   = '0;
            finish_d = 1'b0;
            final_d  = 1'b0;
            state_d  = ST_IDLE;
          end else begin
            emit_d = emit_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      bcount_q    <= '0;
      rnd_q       <= '0;
      emit_q      <= '0;
      first_q     <= 1'b0;
      extra_q     <= 1'b0;
      final_q     <= 1'b0;
      finish_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      bcount_q    <= bcount_d;
      rnd_q       <= rnd_d;
      emit_q      <= emit_d;
      first_q     <= first_d;
      extra_q     <= extra_d;
      final_q     <= final_d;
      finish_q    <= finish_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  sha1sh_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .w_o    (w)
  );

  sha1sh_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (core_ctrl),
    .w_i    (w),
    .word_o (chain_word)
  );

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = out_word_q;
  assign word_index_o  = out_idx_q;
  assign last_word_o   = out_last_q;

endmodule

[hdl/sha1sh_checker.sv]
// ----------------------------------------------------------------------------
// SHA-1 stream hasher port checker
// Port-level properties of the hasher, bound to the top level.
// ----------------------------------------------------------------------------
`include "sha1_stream_hasher_top_macros.svh"

module sha1sh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);

  `SHA1SH_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o,
    "output valid in reset")
  `SHA1SH_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digest_word_o)
    && $stable(word_index_o) && $stable(last_word_o), "stalled digest word changed")
  `SHA1SH_ASSERT(a_last_flag, clk_i, rst_ni,
    out_valid_o |-> (last_word_o == (word_index_o == 3'd4)), "last flag not on word four")
  `SHA1SH_ASSERT(a_busy_emit, clk_i, rst_ni,
    out_valid_o && !last_word_o |-> in_stall_o, "request taken mid digest")
  `SHA1SH_ASSERT(a_first_word, clk_i, rst_ni,
    $rose(out_valid_o) |-> (word_index_o == 3'd0), "digest does not start at word zero")

endmodule

bind sha1_stream_hasher_top sha1sh_checker u_checker (.*);

[tb/sv/sha1_stream_hasher_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 stream hasher testbench
// Feeds byte messages and finish requests through the input channel under
// random bursts and gaps. Output stalls follow a changing pattern and include
// one long hold-off. Every digest word is checked against a SHA-1 digest
// computed inside the bench.
// ----------------------------------------------------------------------------

class sha1_digest_tracker;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic [31:0]  hash_state [5];
  logic [7:0]   block_bytes [64];
  logic [5:0]   byte_fill;
  logic [63:0]  msg_bits;
  digest_word_t expected_words [$];
  int unsigned  errors;
  int unsigned  words_checked;

  function new();
    int i;
    errors = 0;
    words_checked = 0;
    for (i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    load_iv();
  endfunction

  function void load_iv();
    hash_state[0] = 32'h67452301;
    hash_state[1] = 32'hEFCDAB89;
    hash_state[2] = 32'h98BADCFE;
    hash_state[3] = 32'h10325476;
    hash_state[4] = 32'hC3D2E1F0;
    byte_fill = '0;
    msg_bits = '0;
  endfunction

  function void compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    int r;
    for (r = 0; r < 16; r++) begin
      w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
    end
    for (r = 16; r < 80; r++) begin
      x = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
      w[r] = {x[30:0], x[31]};
    end
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
  endfunction

  function void note_request(logic op, logic [7:0] data_v);
    int pos;
    int i;
    digest_word_t dw;
    if (op == sha1sh_pkg::OP_ABSORB) begin
      block_bytes[byte_fill] = data_v;
      msg_bits += 64'd8;
      byte_fill++;
      if (byte_fill == 6'd0) compress();
    end else begin
      pos = byte_fill;
      block_bytes[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin
          block_bytes[pos] = 8'h00;
          pos++;
        end
        compress();
        pos = 0;
      end
      while (pos < 56) begin
        block_bytes[pos] = 8'h00;
        pos++;
      end
      for (i = 0; i < 8; i++) block_bytes[56+i] = msg_bits[63-8*i -: 8];
      compress();
      for (i = 0; i < 5; i++) begin
        dw.word = hash_state[i];
        dw.idx  = 3'(i);
        dw.last = (i == 4);
        expected_words.push_back(dw);
      end
      load_iv();
    end
  endfunction

  function void check_word(logic [31:0] word, logic [2:0] idx, logic last);
    digest_word_t dw;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected digest word %h index %0d", $time, word, idx);
      errors++;
      return;
    end
    dw = expected_words.pop_front();
    words_checked++;
    if (word !== dw.word) begin
      $display("%0t: digest_word expected %h actual %h", $time, dw.word, word);
      errors++;
    end
    if (idx !== dw.idx) begin
      $display("%0t: word_index expected %0d actual %0d", $time, dw.idx, idx);
      errors++;
    end
    if (last !== dw.last) begin
      $display("%0t: last_word expected %0b actual %0b", $time, dw.last, last);
      errors++;
    end
  endfunction

endclass

module sha1_stream_hasher_top_test;

  localparam int  HOLD_CYCLES  = 500;
  localparam int  RANDOM_ITEMS = 450;
  localparam time TIMEOUT_NS   = 12 * 400000;

  typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic        operation   = sha1sh_pkg::OP_ABSORB;
  logic [7:0]  data_byte   = 8'h00;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  sha1_digest_tracker tracker;
  int  burst_left     = 0;
  int  msgs_done      = 0;
  int  bytes_absorbed = 0;
  bit  hold_off_go    = 1'b0;
  bit  hold_off_done  = 1'b0;
  int  boundary_len [4] = '{55, 56, 63, 64};

  sha1_stream_hasher_top u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (operation),
    .data_byte_i   (data_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .digest_word_o (digest_word),
    .word_index_o  (word_index),
    .last_word_o   (last_word)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        tracker.note_request(operation, data_byte);
        if (operation == sha1sh_pkg::OP_FINISH) msgs_done++;
        else bytes_absorbed++;
      end
      if (out_valid && !out_stall) tracker.check_word(digest_word, word_index, last_word);
    end
  end

  task automatic send_request(input logic op, input logic [7:0] data_v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid  <= 1'b1;
    operation <= op;
    data_byte <= data_v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_message(input int len);
    int i;
    for (i = 0; i < len; i++) send_request(sha1sh_pkg::OP_ABSORB, 8'($urandom_range(0, 255)));
    send_request(sha1sh_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    stall_mode_e mode;
    int          mode_left;
    mode = STALL_NONE;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_go && !hold_off_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
        out_stall <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 64);
        end
        mode_left--;
        case (mode)
          STALL_NONE: out_stall <= 1'b0;
          STALL_COIN: out_stall <= 1'($urandom_range(0, 1));
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("sha1_stream_hasher_top_test failed");
    $finish;
  end

  initial begin
    int len;
    int sel;
    int m;
    int rand_items;
    int waited;
    tracker = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(sha1sh_pkg::OP_FINISH, 8'h00);
    send_request(sha1sh_pkg::OP_ABSORB, 8'h61);
    send_request(sha1sh_pkg::OP_ABSORB, 8'h62);
    send_request(sha1sh_pkg::OP_ABSORB, 8'h63);
    send_request(sha1sh_pkg::OP_FINISH, 8'hFF);
    send_request(sha1sh_pkg::OP_ABSORB, 8'h00);
    send_request(sha1sh_pkg::OP_ABSORB, 8'hFF);
    send_request(sha1sh_pkg::OP_FINISH, 8'h5A);
    send_request(sha1sh_pkg::OP_FINISH, 8'hA5);

    m = 0;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (m == 4) hold_off_go = 1'b1;
      if (m < 4) begin
        len = boundary_len[m];
      end else if (hold_off_go && !hold_off_done) begin
        len = $urandom_range(0, 6);
      end else begin
        sel = $urandom_range(0, 9);
        if (sel < 6) len = $urandom_range(0, 12);
        else if (sel < 9) len = $urandom_range(13, 70);
        else len = $urandom_range(100, 140);
      end
      if (m >= 4 && rand_items + len + 1 > RANDOM_ITEMS) len = RANDOM_ITEMS - rand_items - 1;
      send_message(len);
      rand_items += len + 1;
      m++;
    end
    in_valid <= 1'b0;

    waited = 0;
    while (tracker.expected_words.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);

    $display("Hashed %0d messages over %0d bytes and checked %0d digest words",
             msgs_done, bytes_absorbed, tracker.words_checked);
    $display("Lengths included empty, 55, 56, 63 and 64 bytes; output held off %0d cycles once",
             HOLD_CYCLES);
    if (tracker.expected_words.size() != 0) begin
      $display("%0t: %0d digest words never arrived", $time, tracker.expected_words.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("sha1_stream_hasher_top_test passed");
    end else begin
      $display("sha1_stream_hasher_top_test failed");
    end
    $finish;
  end

endmodule
